FILE: src/prtm_pkg.sv
// Shared types and codes for the posted-receive tag matcher.
`default_nettype none

package prtm_pkg;

   localparam logic ACTION_ADD   = 1'b0;
   localparam logic ACTION_MATCH = 1'b1;

   localparam logic [1:0] KIND_RECEIVE         = 2'd0;
   localparam logic [1:0] KIND_BLOCKING_PROBE  = 2'd1;
   localparam logic [1:0] KIND_IMMEDIATE_PROBE = 2'd2;

   localparam logic [4:0] ACTIVE_SOURCES_RESET = 5'd16;

   typedef struct packed {
      logic              action;
      logic [3:0]        source;
      logic              any_source;
      logic signed [15:0] tag;
      logic              any_tag;
      logic [1:0]        request_kind;
      logic [15:0]       fragment_id;
   } req_item_type;

   typedef struct packed {
      logic              matched;
      logic [15:0]       matched_fragment;
      logic [3:0]        matched_source;
      logic signed [15:0] matched_tag;
      logic [15:0]       sequence_number;
      logic              must_post;
      logic              store_full;
   } rsp_type;

   typedef struct packed {
      logic [3:0]        source;
      logic signed [15:0] tag;
      logic [15:0]       handle;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

`default_nettype wire

FILE: src/prtm_chan_if.sv
// Valid/ready channel carrying one payload per transfer.
`default_nettype none

interface prtm_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: src/posted_receive_tag_matcher.sv
// Top level of the posted-receive tag matcher: register port, engine, output register.
//
// Unexpected fragments live in one RAM in arrival order; a match request walks
// the stored entries through the RAM's single read port, one entry per cycle.
// A receive that removes entry k then compacts the later entries, one per
// cycle. One item is worked at a time; a finished result waits in the output
// register while the next item is taken.
`default_nettype none

module posted_receive_tag_matcher import prtm_pkg::*; #(
   parameter int NUM_SOURCES = 16,
   parameter int STORE_DEPTH = 32
) (
   input  wire logic  clock,
   input  wire logic  reset,
   prtm_chan_if.sink  req_ch,
   prtm_chan_if.source rsp_ch,
   prtm_chan_if.sink  csr_ch
);

   logic [4:0] active_ff;
   logic       rsp_valid_ff;
   rsp_type    rsp_ff;
   logic       res_valid;
   logic       res_ready;
   rsp_type    res;

   prtm_engine #(
      .NUM_SOURCES(NUM_SOURCES),
      .STORE_DEPTH(STORE_DEPTH)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .active_sources(active_ff),
      .res_valid     (res_valid),
      .res_ready     (res_ready),
      .res           (res)
   );

   assign csr_ch.ready = 1'b1;
   assign res_ready    = !rsp_valid_ff || rsp_ch.ready;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= ACTIVE_SOURCES_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_ch.valid) begin
            active_ff <= csr_ch.data;
         end
         if (res_valid && res_ready) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (res_valid && res_ready) begin
         rsp_ff <= res;
      end
   end

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("engine took a new transfer while still working");

   a_full_not_matched: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.store_full |-> !rsp_ff.matched && !rsp_ff.must_post)
      else $error("dropped fragment reported as a match result");

   a_post_only_unmatched: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.must_post |-> !rsp_ff.matched)
      else $error("post requested for a matched request");

endmodule

`default_nettype wire

FILE: src/prtm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module prtm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: src/prtm_engine.sv
// Fragment store sequencer: append, ordered scan, and compaction after removal.
`default_nettype none

module prtm_engine import prtm_pkg::*; #(
   parameter int NUM_SOURCES = 16,
   parameter int STORE_DEPTH = 32
) (
   input  wire logic       clock,
   input  wire logic       reset,
   prtm_chan_if.sink       req_ch,
   input  wire logic [4:0] active_sources,
   output      logic       res_valid,
   input  wire logic       res_ready,
   output      rsp_type    res
);

   localparam int IDX_W = $clog2(STORE_DEPTH);
   localparam int CNT_W = $clog2(STORE_DEPTH + 1);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_SHIFT = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [15:0]      seq_ff, seq_in;
   req_item_type     req_ff, req_in;
   logic [CNT_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic             pend_ff, pend_in;
   logic             pend_last_ff, pend_last_in;
   logic [IDX_W-1:0] pend_idx_ff, pend_idx_in;
   logic             found_ff, found_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   entry_type        best_ff, best_in;
   rsp_type          res_ff, res_in;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic [ENTRY_W-1:0] rd_raw;
   entry_type        rd_entry;

   logic             tag_hit;
   logic             src_hit;
   logic             take;
   logic             fin_found;
   logic [IDX_W-1:0] fin_idx;
   entry_type        fin_entry;

   prtm_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(STORE_DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_raw)
   );

   assign rd_entry   = entry_type'(rd_raw);
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign res_valid  = (state_ff == ST_DONE);
   assign res        = res_ff;

   always_comb begin
      tag_hit = req_ff.any_tag ? !rd_entry.tag[15] : (rd_entry.tag == req_ff.tag);
      if (req_ff.any_source) begin
         src_hit = ({1'b0, rd_entry.source} < active_sources) &&
                   (int'(rd_entry.source) < NUM_SOURCES);
      end else begin
         src_hit = (rd_entry.source == req_ff.source);
      end
      take = tag_hit && src_hit &&
             (!found_ff || (req_ff.any_source && rd_entry.source < best_ff.source));
      fin_found = found_ff || take;
      fin_idx   = take ? pend_idx_ff : best_idx_ff;
      fin_entry = take ? rd_entry : best_ff;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      seq_in       = seq_ff;
      req_in       = req_ff;
      rd_ptr_in    = rd_ptr_ff;
      pend_in      = 1'b0;
      pend_last_in = pend_last_ff;
      pend_idx_in  = pend_idx_ff;
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_in      = best_ff;
      res_in       = res_ff;
      wr_en        = 1'b0;
      wr_addr      = count_ff[IDX_W-1:0];
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = rd_ptr_ff[IDX_W-1:0];

      if ((state_ff == ST_SCAN || state_ff == ST_SHIFT) && rd_ptr_ff < count_ff) begin
         rd_en        = 1'b1;
         rd_ptr_in    = rd_ptr_ff + CNT_W'(1);
         pend_in      = 1'b1;
         pend_idx_in  = rd_ptr_ff[IDX_W-1:0];
         pend_last_in = (rd_ptr_ff == count_ff - CNT_W'(1));
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               res_in = '0;
               if (req_ch.data.action == ACTION_ADD) begin
                  if (count_ff == CNT_W'(STORE_DEPTH)) begin
                     res_in.store_full = 1'b1;
                  end else begin
                     wr_en          = 1'b1;
                     wr_data.source = req_ch.data.source;
                     wr_data.tag    = req_ch.data.tag;
                     wr_data.handle = req_ch.data.fragment_id;
                     count_in       = count_ff + CNT_W'(1);
                  end
                  state_in = ST_DONE;
               end else begin
                  req_in                 = req_ch.data;
                  seq_in                 = seq_ff + 16'd1;
                  res_in.sequence_number = seq_ff;
                  found_in               = 1'b0;
                  rd_ptr_in              = '0;
                  if (count_ff == '0) begin
                     res_in.must_post = (req_ch.data.request_kind != KIND_IMMEDIATE_PROBE);
                     state_in         = ST_DONE;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end
            end
         end
         ST_SCAN: begin
            if (pend_ff) begin
               if (take) begin
                  found_in    = 1'b1;
                  best_idx_in = pend_idx_ff;
                  best_in     = rd_entry;
               end
               if (pend_last_ff) begin
                  state_in = ST_DONE;
                  if (fin_found) begin
                     res_in.matched          = 1'b1;
                     res_in.matched_fragment = fin_entry.handle;
                     res_in.matched_source   = fin_entry.source;
                     res_in.matched_tag      = fin_entry.tag;
                     if (req_ff.request_kind != KIND_BLOCKING_PROBE &&
                         req_ff.request_kind != KIND_IMMEDIATE_PROBE) begin
                        if (CNT_W'(fin_idx) + CNT_W'(1) == count_ff) begin
                           count_in = count_ff - CNT_W'(1);
                        end else begin
                           rd_ptr_in = CNT_W'(fin_idx) + CNT_W'(1);
                           state_in  = ST_SHIFT;
                        end
                     end
                  end else begin
                     res_in.must_post = (req_ff.request_kind != KIND_IMMEDIATE_PROBE);
                  end
               end
            end
         end
         ST_SHIFT: begin
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = pend_idx_ff - IDX_W'(1);
               wr_data = rd_entry;
               if (pend_last_ff) begin
                  count_in = count_ff - CNT_W'(1);
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         seq_ff   <= '0;
         pend_ff  <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         seq_ff   <= seq_in;
         pend_ff  <= pend_in;
         found_ff <= found_in;
      end
      req_ff       <= req_in;
      rd_ptr_ff    <= rd_ptr_in;
      pend_last_ff <= pend_last_in;
      pend_idx_ff  <= pend_idx_in;
      best_idx_ff  <= best_idx_in;
      best_ff      <= best_in;
      res_ff       <= res_in;
   end

endmodule

`default_nettype wire

FILE: bench/posted_receive_tag_matcher_tb.sv
// Self-checking bench for the posted-receive tag matcher: directed and random transfers.
module posted_receive_tag_matcher_tb import prtm_pkg::*;;

   localparam int NUM_SOURCES = 16;
   localparam int STORE_DEPTH = 32;
   localparam int QUIET_LIMIT = 4000;
   localparam int SEGMENT_ITEMS = 205;
   localparam logic [1:0] KIND_UNKNOWN = 2'd3;

   typedef enum {BURST_FILL, BURST_DRAIN, BURST_MIX} burst_type;

   class match_scoreboard_type;
      entry_type   held[$];
      rsp_type     awaited[$];
      logic [15:0] seq_next;
      logic [4:0]  search_count;
      int          errors;
      int          checked;
      int          hits;
      int          drops;
      int          requests;

      function new();
         seq_next = '0;
         search_count = ACTIVE_SOURCES_RESET;
         errors = 0;
         checked = 0;
         hits = 0;
         drops = 0;
         requests = 0;
      endfunction

      function void set_search_count(logic [4:0] value);
         search_count = value;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function void note_request(req_item_type r);
         rsp_type e;
         entry_type fresh;
         int best;
         int limit;
         logic tag_hit;
         e = '0;
         requests++;
         if (r.action == ACTION_ADD) begin
            if (held.size() >= STORE_DEPTH) begin
               e.store_full = 1'b1;
               drops++;
            end else begin
               fresh.source = r.source;
               fresh.tag = r.tag;
               fresh.handle = r.fragment_id;
               held.push_back(fresh);
            end
         end else begin
            e.sequence_number = seq_next;
            seq_next = seq_next + 16'd1;
            limit = (search_count > NUM_SOURCES) ? NUM_SOURCES : int'(search_count);
            best = -1;
            foreach (held[i]) begin
               tag_hit = r.any_tag ? !held[i].tag[15] : (held[i].tag == r.tag);
               if (tag_hit) begin
                  if (r.any_source) begin
                     if (int'(held[i].source) < limit &&
                         (best < 0 || held[i].source < held[best].source))
                        best = i;
                  end else if (held[i].source == r.source && best < 0) begin
                     best = i;
                  end
               end
            end
            if (best >= 0) begin
               e.matched = 1'b1;
               e.matched_fragment = held[best].handle;
               e.matched_source = held[best].source;
               e.matched_tag = held[best].tag;
               if (r.request_kind != KIND_BLOCKING_PROBE &&
                   r.request_kind != KIND_IMMEDIATE_PROBE)
                  held.delete(best);
            end else begin
               e.must_post = (r.request_kind != KIND_IMMEDIATE_PROBE);
            end
         end
         awaited.push_back(e);
      endfunction

      function void compare_field(string name, logic signed [31:0] want,
                                  logic signed [31:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (awaited.size() == 0) begin
            $error("result with no request outstanding: %h", got);
            errors++;
            return;
         end
         want = awaited.pop_front();
         checked++;
         if (want.matched)
            hits++;
         compare_field("matched", want.matched, got.matched);
         compare_field("matched_fragment", want.matched_fragment, got.matched_fragment);
         compare_field("matched_source", want.matched_source, got.matched_source);
         compare_field("matched_tag", want.matched_tag, got.matched_tag);
         compare_field("sequence_number", want.sequence_number, got.sequence_number);
         compare_field("must_post", want.must_post, got.must_post);
         compare_field("store_full", want.store_full, got.store_full);
      endfunction
   endclass

   logic clock;
   logic reset;

   prtm_chan_if #(.payload_type(req_item_type)) req_if ();
   prtm_chan_if #(.payload_type(rsp_type)) rsp_if ();
   prtm_chan_if #(.payload_type(logic [4:0])) csr_if ();

   posted_receive_tag_matcher #(
      .NUM_SOURCES(NUM_SOURCES),
      .STORE_DEPTH(STORE_DEPTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_if.sink),
      .rsp_ch(rsp_if.source),
      .csr_ch(csr_if.sink)
   );

   match_scoreboard_type board = new();

   int unsigned send_idle_pct;
   int unsigned take_idle_pct;
   int unsigned stall_asks;
   int unsigned stall_served;
   int unsigned stall_left;
   int          quiet;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver: take results, honor long hold-off requests
   initial begin
      stall_left = 0;
      stall_served = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
            board.check_result(rsp_if.data);
         if (stall_asks != stall_served) begin
            stall_left = 250;
            stall_served = stall_asks;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= take_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   function automatic req_item_type make_req(logic action, logic [3:0] src, logic any_src,
                                             logic signed [15:0] tag, logic any_tag,
                                             logic [1:0] kind, logic [15:0] id);
      req_item_type r;
      r.action = action;
      r.source = src;
      r.any_source = any_src;
      r.tag = tag;
      r.any_tag = any_tag;
      r.request_kind = kind;
      r.fragment_id = id;
      return r;
   endfunction

   function automatic req_item_type random_item(burst_type b);
      req_item_type r;
      int unsigned pick;
      r.fragment_id = 16'($urandom);
      r.source = ($urandom_range(9) < 7) ? 4'($urandom_range(3)) : 4'($urandom_range(15));
      pick = $urandom_range(9);
      r.tag = (pick < 6) ? 16'($urandom_range(6) - 3) :
              (pick < 8) ? 16'($urandom) : 16'($urandom_range(3));
      r.any_source = ($urandom_range(9) < 4);
      r.any_tag = ($urandom_range(9) < 4);
      pick = $urandom_range(9);
      r.request_kind = (pick < 5) ? KIND_RECEIVE : (pick < 7) ? KIND_BLOCKING_PROBE :
                       (pick < 9) ? KIND_IMMEDIATE_PROBE : KIND_UNKNOWN;
      pick = $urandom_range(9);
      case (b)
         BURST_FILL:  r.action = (pick < 9) ? ACTION_ADD : ACTION_MATCH;
         BURST_DRAIN: r.action = (pick < 9) ? ACTION_MATCH : ACTION_ADD;
         default:     r.action = (pick < 5) ? ACTION_ADD : ACTION_MATCH;
      endcase
      return r;
   endfunction

   task automatic send_req(input req_item_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data <= item;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      board.note_request(item);
   endtask

   task automatic write_search_count(input logic [4:0] value);
      req_if.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (STORE_DEPTH + 8) @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.data <= value;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      csr_if.valid <= 1'b0;
      board.set_search_count(value);
   endtask

   initial begin
      int seg;
      int left;
      int len;
      int k;
      burst_type b;
      logic [4:0] plan;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.data = '0;
      csr_if.valid = 1'b0;
      csr_if.data = '0;
      send_idle_pct = 0;
      take_idle_pct = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed pass at the reset search count
      send_req(make_req(ACTION_MATCH, 4'd0, 1'b0, 16'sd0, 1'b0, KIND_RECEIVE, 16'h0000));
      send_req(make_req(ACTION_MATCH, 4'd9, 1'b1, 16'sd7, 1'b1, KIND_IMMEDIATE_PROBE, 16'h0));
      send_req(make_req(ACTION_ADD, 4'd15, 1'b1, -16'sd32768, 1'b1, KIND_UNKNOWN, 16'hFFFF));
      send_req(make_req(ACTION_ADD, 4'd0, 1'b0, 16'sd32767, 1'b0, KIND_RECEIVE, 16'h0000));
      send_req(make_req(ACTION_ADD, 4'd3, 1'b0, 16'sd0, 1'b0, KIND_RECEIVE, 16'h0001));
      send_req(make_req(ACTION_ADD, 4'd3, 1'b0, 16'sd5, 1'b0, KIND_RECEIVE, 16'h0002));
      send_req(make_req(ACTION_ADD, 4'd1, 1'b0, -16'sd1, 1'b0, KIND_RECEIVE, 16'h0003));
      send_req(make_req(ACTION_ADD, 4'd2, 1'b0, 16'sd0, 1'b0, KIND_RECEIVE, 16'h0004));
      send_req(make_req(ACTION_MATCH, 4'd0, 1'b1, 16'sd0, 1'b1, KIND_BLOCKING_PROBE, 16'h0));
      send_req(make_req(ACTION_MATCH, 4'd0, 1'b1, 16'sd0, 1'b1, KIND_RECEIVE, 16'h0));
      send_req(make_req(ACTION_MATCH, 4'd15, 1'b0, 16'sd0, 1'b1, KIND_RECEIVE, 16'h0));
      send_req(make_req(ACTION_MATCH, 4'd15, 1'b0, -16'sd32768, 1'b0, KIND_RECEIVE, 16'h0));
      send_req(make_req(ACTION_MATCH, 4'd0, 1'b1, 16'sd0, 1'b0, KIND_UNKNOWN, 16'h0));
      send_req(make_req(ACTION_MATCH, 4'd1, 1'b0, -16'sd1, 1'b0, KIND_IMMEDIATE_PROBE, 16'h0));
      send_req(make_req(ACTION_MATCH, 4'd0, 1'b1, -16'sd1, 1'b1, KIND_RECEIVE, 16'h0));
      send_req(make_req(ACTION_MATCH, 4'd3, 1'b0, 16'sd5, 1'b0, KIND_BLOCKING_PROBE, 16'h0));
      send_req(make_req(ACTION_ADD, 4'd7, 1'b0, 16'sd12345, 1'b0, KIND_RECEIVE, 16'hA5A5));
      send_req(make_req(ACTION_MATCH, 4'd7, 1'b0, 16'sd12345, 1'b0, KIND_RECEIVE, 16'h5A5A));
      send_req(make_req(ACTION_MATCH, 4'd1, 1'b0, -16'sd1, 1'b1, KIND_RECEIVE, 16'h0));

      for (seg = 0; seg < 6; seg++) begin
         send_idle_pct = (seg < 2) ? 24 : (seg < 4) ? 61 : 0;
         take_idle_pct = (seg < 2) ? 61 : (seg < 4) ? 24 : 0;
         case (seg)
            0: plan = 5'd1;
            1: plan = 5'd0;
            2: plan = 5'd31;
            3: plan = 5'($urandom_range(15, 2));
            4: plan = 5'd16;
            default: plan = 5'($urandom_range(16, 1));
         endcase
         write_search_count(plan);
         if (seg == 0 || seg == 4)
            stall_asks++;
         left = SEGMENT_ITEMS;
         while (left > 0) begin
            b = burst_type'($urandom_range(2));
            len = (b == BURST_FILL) ? $urandom_range(36, 30) : $urandom_range(30, 8);
            for (k = 0; k < len && left > 0; k++) begin
               send_req(random_item(b));
               left--;
            end
         end
      end

      req_if.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (STORE_DEPTH + 8) @(posedge clock);
      $display("covered %0d requests over six search counts: %0d results checked,",
               board.requests, board.checked);
      $display("  %0d matched, %0d fragments dropped on a full store",
               board.hits, board.drops);
      if (board.errors == 0 && board.pending() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
